// File: src/rse_pkg.sv
// Package for the reverse Polish stack evaluator: widths, command codes,
// the token kind enum and the token word passed from front end to back end.
// No dependencies.
`timescale 1ns / 1ps

package rse_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    typedef enum logic [2:0] {
        K_PUSH = 3'd0,
        K_ADD  = 3'd1,
        K_SUB  = 3'd2,
        K_MUL  = 3'd3,
        K_DIV  = 3'd4,
        K_NONE = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  number;
        logic               last;
    } t_token;

endpackage

// File: src/rse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rse_front.sv
// Front end: accepts tokens, classifies the command code and holds them in
// a short queue for the back end. Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rse_pkg::CMD_W-1:0]      i_command,
    input  logic [rse_pkg::DATA_W-1:0]     i_number,
    input  logic                           i_last_token,
    output logic                           o_busy,
    output logic                           o_tok_valid,
    output rse_pkg::t_token                o_tok,
    input  logic                           i_pop
);
    import rse_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_token           r_q [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wptr, n_wptr;
    logic [QAW-1:0]   r_rptr, n_rptr;
    logic [QCW-1:0]   r_count, n_count;
    t_kind            kind;
    logic             push;

    always_comb begin
        case (i_command)
            CMD_PUSH: kind = K_PUSH;
            CMD_ADD:  kind = K_ADD;
            CMD_SUB:  kind = K_SUB;
            CMD_MUL:  kind = K_MUL;
            CMD_DIV:  kind = K_DIV;
            default:  kind = K_NONE;
        endcase
    end

    assign o_busy      = (r_count == QCW'(QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_tok_valid = (r_count != '0);
    assign o_tok       = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QAW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QAW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{kind: kind, number: i_number, last: i_last_token};
        end
    end

endmodule

// File: src/rse_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rse_pkg::DATA_W-1:0] i_dividend,
    input  logic [rse_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rse_pkg::DATA_W-1:0] o_quotient
);
    import rse_pkg::*;

    localparam int CW = $clog2(DATA_W);

    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_run;
    logic              r_done;
    logic [DATA_W:0]   shifted;
    logic              take;

    assign shifted = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign take    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= take ? (shifted - {1'b0, r_dvs}) : shifted;
            r_quo <= {r_quo[DATA_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/rse_back.sv
// Back end: executes queued tokens on the operand stack and emits results.
// Depends on rse_pkg, rse_ram and rse_div.
`timescale 1ns / 1ps

module rse_back #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tok_valid,
    input  rse_pkg::t_token            i_tok,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [rse_pkg::DATA_W-1:0] o_answer,
    output logic                       o_stack_was_empty,
    output logic                       o_divide_by_zero_seen,
    output logic                       o_overflow_seen
);
    import rse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [DATA_W-1:0] r_top, n_top;
    t_kind             r_kind, n_kind;
    logic              r_last, n_last;
    logic              r_dz, n_dz;
    logic              r_ov, n_ov;
    logic              r_qneg, n_qneg;
    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_answer, n_answer;
    logic              r_empty, n_empty;
    logic              r_dz_out, n_dz_out;
    logic              r_ov_out, n_ov_out;

    logic [FW-1:0]     fill_m1, fill_m2;
    logic              we;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] opa, opb, mag_a, mag_b, prod;
    logic              div_start, div_done;
    logic [DATA_W-1:0] quo;
    t_state            after_tok;

    assign fill_m1 = r_fill - FW'(1);
    assign fill_m2 = r_fill - FW'(2);

    rse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(fill_m1[AW-1:0]),
        .i_wdata(r_top),
        .i_raddr(fill_m2[AW-1:0]),
        .o_rdata(rdata)
    );

    // The top of stack lives in r_top; the RAM holds the entries below it.
    assign opa   = rdata;
    assign opb   = r_top;
    assign mag_a = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
    assign mag_b = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
    assign prod  = opa * opb;

    rse_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(mag_a),
        .i_divisor (mag_b),
        .o_done    (div_done),
        .o_quotient(quo)
    );

    assign after_tok = r_last ? S_FIN : S_IDLE;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_top     = r_top;
        n_kind    = r_kind;
        n_last    = r_last;
        n_dz      = r_dz;
        n_ov      = r_ov;
        n_qneg    = r_qneg;
        n_valid   = 1'b0;
        n_answer  = r_answer;
        n_empty   = r_empty;
        n_dz_out  = r_dz_out;
        n_ov_out  = r_ov_out;
        we        = 1'b0;
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_pop   = 1'b1;
                    n_kind  = i_tok.kind;
                    n_last  = i_tok.last;
                    n_state = i_tok.last ? S_FIN : S_IDLE;
                    if (i_tok.kind == K_PUSH) begin
                        if (r_fill != FW'(STACK_DEPTH)) begin
                            we     = (r_fill != '0);
                            n_top  = i_tok.number;
                            n_fill = r_fill + FW'(1);
                        end else begin
                            n_ov = 1'b1;
                        end
                    end else if ((i_tok.kind inside {K_ADD, K_SUB, K_MUL, K_DIV})
                                 && (r_fill >= FW'(2))) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = after_tok;
                n_fill  = fill_m1;
                case (r_kind)
                    K_ADD:   n_top = opa + opb;
                    K_SUB:   n_top = opa - opb;
                    K_MUL:   n_top = prod;
                    default: begin
                        if (opb == '0) begin
                            n_top = '0;
                            n_dz  = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_qneg    = opa[DATA_W-1] ^ opb[DATA_W-1];
                            n_fill    = r_fill;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_top   = r_qneg ? (~quo + DATA_W'(1)) : quo;
                    n_fill  = fill_m1;
                    n_state = after_tok;
                end
            end
            S_FIN: begin
                n_valid  = 1'b1;
                n_answer = (r_fill != '0) ? r_top : '0;
                n_empty  = (r_fill == '0);
                n_dz_out = r_dz;
                n_ov_out = r_ov;
                n_fill   = '0;
                n_dz     = 1'b0;
                n_ov     = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_dz    <= 1'b0;
            r_ov    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_dz    <= n_dz;
            r_ov    <= n_ov;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_kind   <= n_kind;
        r_last   <= n_last;
        r_qneg   <= n_qneg;
        r_answer <= n_answer;
        r_empty  <= n_empty;
        r_dz_out <= n_dz_out;
        r_ov_out <= n_ov_out;
    end

    assign o_valid               = r_valid;
    assign o_answer              = r_answer;
    assign o_stack_was_empty     = r_empty;
    assign o_divide_by_zero_seen = r_dz_out;
    assign o_overflow_seen       = r_ov_out;

endmodule

// File: src/rpn_stack_evaluator_top.sv
// Reverse Polish stack evaluator, top level. A popped push goes to the top register;
// add/sub/mul pass S_READ, divide S_READ and S_DIV (32-step divider), last adds S_FIN.
// Throughput is one token per back-end pass; a two-word token queue absorbs bursts.
// Results appear for one cycle on o_valid and cannot be stalled by the receiver.
// Reset (i_rst_n low, synchronous) empties queue and stack and clears the sticky flags.
// Depends on rse_pkg, rse_front, rse_back (with rse_ram and rse_div).
`timescale 1ns / 1ps

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rse_pkg::CMD_W-1:0]  i_command,
    input  logic [rse_pkg::DATA_W-1:0] i_number,
    input  logic                       i_last_token,
    output logic                       o_valid,
    output logic [rse_pkg::DATA_W-1:0] o_answer,
    output logic                       o_stack_was_empty,
    output logic                       o_divide_by_zero_seen,
    output logic                       o_overflow_seen
);
    import rse_pkg::*;

    // A word is taken whenever start is high and busy is low. Busy only
    // reflects a full token queue, so the front end keeps accepting words
    // while the back end is still grinding through a division.
    logic   tok_valid;
    t_token tok;
    logic   pop;

    // The front end turns the raw command code into a token kind; unknown
    // codes become a kind that the back end simply discards.
    rse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_command   (i_command),
        .i_number    (i_number),
        .i_last_token(i_last_token),
        .o_busy      (busy),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_pop       (pop)
    );

    // The back end keeps the top of stack in a register and the deeper
    // entries in a RAM, so an operator needs just one RAM read. It owns the
    // sticky flags and the registered result outputs.
    rse_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_tok_valid          (tok_valid),
        .i_tok                (tok),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .o_answer             (o_answer),
        .o_stack_was_empty    (o_stack_was_empty),
        .o_divide_by_zero_seen(o_divide_by_zero_seen),
        .o_overflow_seen      (o_overflow_seen)
    );

endmodule

// File: src/rse_checker.sv
// Port-level checker for the stack evaluator, bound to the top level.
// Depends on rse_pkg and rpn_stack_evaluator_top.
`timescale 1ns / 1ps

module rse_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [rse_pkg::DATA_W-1:0] o_answer,
    input logic                       o_stack_was_empty
);

    // Reset clears the result strobe on the following edge.
    a_reset_clears_valid: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe not cleared by reset");

    // An empty stack reports a zero answer.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_was_empty) |-> (o_answer == '0))
        else $error("empty stack with nonzero answer");

    // The result stage always passes through idle, so strobes never abut.
    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in consecutive cycles");

    // The queue can only fill up right after a word was taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted word");

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_answer         (o_answer),
    .o_stack_was_empty(o_stack_was_empty)
);

// File: sim/rse_result_checker.sv
// Result checker for the reverse Polish stack evaluator: watches the token and
// result channels, predicts each result and compares it field by field.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_result_checker #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [rse_pkg::CMD_W-1:0]  i_command,
    input  logic [rse_pkg::DATA_W-1:0] i_number,
    input  logic                       i_last_token,
    input  logic                       i_valid,
    input  logic [rse_pkg::DATA_W-1:0] i_answer,
    input  logic                       i_stack_was_empty,
    input  logic                       i_divide_by_zero_seen,
    input  logic                       i_overflow_seen,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_empty_results,
    output int                         o_zero_div_results,
    output int                         o_overflow_results
);

    import rse_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] answer;
        logic              was_empty;
        logic              div_zero;
        logic              overflow;
    } t_outcome;

    t_outcome          outcome_q[$];
    logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
    int                stack_fill;
    logic              zero_div_flag;
    logic              full_drop_flag;

    initial begin
        o_errors           = 0;
        o_pending          = 0;
        o_results          = 0;
        o_empty_results    = 0;
        o_zero_div_results = 0;
        o_overflow_results = 0;
        stack_fill         = 0;
        zero_div_flag      = 1'b0;
        full_drop_flag     = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("ERROR at %0t: %s, got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    // Signed quotient rounded toward zero; the most negative value over -1
    // wraps back to itself through the magnitude arithmetic.
    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_num;
        logic [DATA_W-1:0] mag_den;
        logic [DATA_W-1:0] quo;
        mag_num = num[DATA_W-1] ? -num : num;
        mag_den = den[DATA_W-1] ? -den : den;
        quo     = mag_num / mag_den;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    function automatic logic [DATA_W-1:0] combine(input logic [CMD_W-1:0] cmd,
                                                  input logic [DATA_W-1:0] lhs,
                                                  input logic [DATA_W-1:0] rhs);
        logic [DATA_W-1:0] res;
        case (cmd)
            CMD_ADD: res = lhs + rhs;
            CMD_SUB: res = lhs - rhs;
            CMD_MUL: res = lhs * rhs;
            default: res = (rhs == '0) ? '0 : trunc_quotient(lhs, rhs);
        endcase
        return res;
    endfunction

    task automatic take_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] num,
                             input logic last);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        t_outcome          outcome;
        if (cmd == CMD_PUSH) begin
            if (stack_fill < STACK_DEPTH) begin
                operand_stack[stack_fill] = num;
                stack_fill++;
            end else begin
                full_drop_flag = 1'b1;
            end
        end else if ((cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL || cmd == CMD_DIV)
                     && stack_fill >= 2) begin
            rhs = operand_stack[stack_fill-1];
            lhs = operand_stack[stack_fill-2];
            if (cmd == CMD_DIV && rhs == '0) begin
                zero_div_flag = 1'b1;
            end
            operand_stack[stack_fill-2] = combine(cmd, lhs, rhs);
            stack_fill--;
        end
        if (last) begin
            if (stack_fill > 0) begin
                outcome.answer    = operand_stack[stack_fill-1];
                outcome.was_empty = 1'b0;
            end else begin
                outcome.answer    = '0;
                outcome.was_empty = 1'b1;
            end
            outcome.div_zero = zero_div_flag;
            outcome.overflow = full_drop_flag;
            outcome_q.insert(outcome_q.size(), outcome);
            o_empty_results    += int'(outcome.was_empty);
            o_zero_div_results += int'(outcome.div_zero);
            o_overflow_results += int'(outcome.overflow);
            stack_fill     = 0;
            zero_div_flag  = 1'b0;
            full_drop_flag = 1'b0;
        end
    endtask

    task automatic check_result();
        t_outcome want;
        o_results++;
        if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing expected", i_answer, '0);
        end else begin
            want = outcome_q.pop_front();
            if (i_answer !== want.answer)
                report_mismatch("answer", i_answer, want.answer);
            if (i_stack_was_empty !== want.was_empty)
                report_mismatch("stack_was_empty", DATA_W'(i_stack_was_empty),
                                DATA_W'(want.was_empty));
            if (i_divide_by_zero_seen !== want.div_zero)
                report_mismatch("divide_by_zero_seen", DATA_W'(i_divide_by_zero_seen),
                                DATA_W'(want.div_zero));
            if (i_overflow_seen !== want.overflow)
                report_mismatch("overflow_seen", DATA_W'(i_overflow_seen),
                                DATA_W'(want.overflow));
        end
    endtask

    // Sampled at the clock edge, before the nonblocking updates of that edge land.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outcome_q.delete();
            stack_fill     = 0;
            zero_div_flag  = 1'b0;
            full_drop_flag = 1'b0;
        end else begin
            if (i_valid === 1'b1) begin
                check_result();
            end
            if (i_start && !i_busy) begin
                take_word(i_command, i_number, i_last_token);
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// File: sim/rpn_stack_evaluator_top_tb.sv
// Testbench top for the reverse Polish stack evaluator: drives directed and
// random token words with random idle gaps and gives the verdict.
// Depends on rse_pkg, rpn_stack_evaluator_top and rse_result_checker.
`timescale 1ns / 1ps

module rpn_stack_evaluator_top_tb;

    import rse_pkg::*;

    localparam int     RESET_CYCLES = 12;
    localparam int     WORD_TARGET  = 1400;
    // The slowest word is a divide plus the finish step for a last token;
    // the drain wait after the final result covers that with margin.
    localparam int     DRAIN_CYCLES = 64;
    // Worst case is roughly 1600 words, each taking a full divide and the
    // longest idle gap. The limit is far above that.
    localparam longint CYCLE_LIMIT  = 1_000_000;

    // Command codes the block does not define; it must ignore them.
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam logic [DATA_W-1:0] NUM_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NUM_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] NUM_NEG1 = 32'hFFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic [CMD_W-1:0]  i_command    = CMD_PUSH;
    logic [DATA_W-1:0] i_number     = '0;
    logic              i_last_token = 1'b0;
    logic              busy;
    logic              o_valid;
    logic [DATA_W-1:0] o_answer;
    logic              o_stack_was_empty;
    logic              o_divide_by_zero_seen;
    logic              o_overflow_seen;

    int     fail_count;
    int     pending_results;
    int     results_seen;
    int     empty_results;
    int     zero_div_results;
    int     overflow_results;
    int     words_sent   = 0;
    int     useful_words = 0;
    int     expressions  = 0;
    bit     no_idle      = 1'b0;
    longint cycle_count  = 0;

    rpn_stack_evaluator_top #(
        .STACK_DEPTH (STACK_DEPTH_DEF)
    ) uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_command             (i_command),
        .i_number              (i_number),
        .i_last_token          (i_last_token),
        .o_valid               (o_valid),
        .o_answer              (o_answer),
        .o_stack_was_empty     (o_stack_was_empty),
        .o_divide_by_zero_seen (o_divide_by_zero_seen),
        .o_overflow_seen       (o_overflow_seen)
    );

    // The checker sits beside the block and sees exactly what the block sees.
    rse_result_checker #(
        .STACK_DEPTH (STACK_DEPTH_DEF)
    ) u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (start),
        .i_busy                (busy),
        .i_command             (i_command),
        .i_number              (i_number),
        .i_last_token          (i_last_token),
        .i_valid               (o_valid),
        .i_answer              (o_answer),
        .i_stack_was_empty     (o_stack_was_empty),
        .i_divide_by_zero_seen (o_divide_by_zero_seen),
        .i_overflow_seen       (o_overflow_seen),
        .o_errors              (fail_count),
        .o_pending             (pending_results),
        .o_results             (results_seen),
        .o_empty_results       (empty_results),
        .o_zero_div_results    (zero_div_results),
        .o_overflow_results    (overflow_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle gap after a word: mostly none, sometimes a short one, now and
    // then a long one so that gaps land on every stage of a divide.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return 0;
        else if (roll < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Operand values lean toward the interesting corners: zero (to provoke
    // divide by zero), the extremes, minus one and small signed numbers.
    function automatic logic [DATA_W-1:0] pick_number();
        logic [DATA_W-1:0] val;
        case ($urandom_range(0, 15))
            0:       val = '0;
            1:       val = NUM_MIN;
            2:       val = NUM_MAX;
            3:       val = NUM_NEG1;
            4:       val = 32'd1;
            5, 6, 7, 8: begin
                val = $urandom_range(0, 40);
                val = val - 32'd20;
            end
            default: val = $urandom;
        endcase
        return val;
    endfunction

    function automatic logic [CMD_W-1:0] pick_operator();
        logic [CMD_W-1:0] op;
        case ($urandom_range(0, 3))
            0:       op = CMD_ADD;
            1:       op = CMD_SUB;
            2:       op = CMD_MUL;
            default: op = CMD_DIV;
        endcase
        return op;
    endfunction

    // Presents one word and holds it until the block takes it. Start stays
    // high across back-to-back words so it is never lowered and raised in
    // the same time step.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] num,
                             input logic last);
        int gap;
        start        <= 1'b1;
        i_command    <= cmd;
        i_number     <= num;
        i_last_token <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
        if (cmd == CMD_PUSH || cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL
            || cmd == CMD_DIV)
            useful_words++;
        if (last)
            expressions++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one well-formed expression with the given number of operands.
    // With push_first set, every operand goes on before any operator, which
    // drives the stack to full and beyond. With noisy set, stray words (any
    // code, spare ones included) are slipped in to break the sequence.
    task automatic run_expression(input int operands, input bit push_first, input bit noisy);
        int  pushes_left;
        int  depth;
        bit  do_op;
        bit  last;
        if (operands == 0) begin
            // Nothing on the stack: an operator marked last gives an empty result.
            send_word(pick_operator(), pick_number(), 1'b1);
        end else begin
            pushes_left = operands;
            depth       = 0;
            while (pushes_left > 0 || depth > 1) begin
                if (noisy && $urandom_range(0, 7) == 0)
                    send_word(CMD_W'($urandom_range(0, 7)), pick_number(), 1'b0);
                do_op = depth >= 2 && (pushes_left == 0
                        || (!push_first && $urandom_range(0, 2) == 0));
                if (do_op) begin
                    depth--;
                end else begin
                    pushes_left--;
                    depth++;
                end
                last = pushes_left == 0 && depth <= 1;
                if (do_op)
                    send_word(pick_operator(), pick_number(), last);
                else
                    send_word(CMD_PUSH, pick_number(), last);
            end
        end
    endtask

    initial begin
        int  pick;
        bit  first_random;

        // Synchronous reset held for a fixed count, then released once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An operator on an empty stack, marked last, is
        // ignored and leaves an empty result.
        send_word(CMD_ADD, NUM_MAX, 1'b1);
        // A single push marked last.
        send_word(CMD_PUSH, 32'd5, 1'b1);
        // Most negative over minus one wraps; then maximum minus most
        // negative wraps to minus one; then minus one over zero gives zero
        // and sets the sticky flag. Spare codes pass through untouched.
        send_word(CMD_PUSH, NUM_MAX, 1'b0);
        send_word(CMD_PUSH, NUM_MIN, 1'b0);
        send_word(CMD_PUSH, NUM_NEG1, 1'b0);
        send_word(CMD_DIV, '0, 1'b0);
        send_word(CMD_SUB, NUM_NEG1, 1'b0);
        send_word(CMD_PUSH, '0, 1'b0);
        send_word(CMD_DIV, NUM_MIN, 1'b0);
        send_word(CMD_SPARE5, NUM_MAX, 1'b0);
        send_word(CMD_SPARE6, NUM_NEG1, 1'b0);
        send_word(CMD_SPARE7, NUM_MIN, 1'b0);
        send_word(CMD_PUSH, 32'd3, 1'b0);
        send_word(CMD_MUL, '0, 1'b0);
        send_word(CMD_PUSH, -32'sd7, 1'b0);
        send_word(CMD_ADD, '0, 1'b1);
        // Mixed-sign division truncates toward zero: 7 / -2 is -3.
        send_word(CMD_PUSH, 32'd7, 1'b0);
        send_word(CMD_PUSH, -32'sd2, 1'b0);
        send_word(CMD_DIV, '0, 1'b1);
        // Spare code marked last on an empty stack.
        send_word(CMD_SPARE7, NUM_MAX, 1'b1);

        // Random part. Most expressions are well formed with random content;
        // some overfill the stack, some are empty and some carry noise. Runs
        // of expressions go without any idle gap at all.
        first_random = 1'b1;
        while (useful_words < WORD_TARGET) begin
            no_idle = $urandom_range(0, 3) == 0;
            pick    = $urandom_range(0, 19);
            if (first_random || pick == 0)
                run_expression($urandom_range(STACK_DEPTH_DEF - 1, STACK_DEPTH_DEF + 4),
                               1'b1, 1'b0);
            else if (pick == 1)
                run_expression(0, 1'b0, 1'b0);
            else if (pick <= 4)
                run_expression($urandom_range(1, 8), 1'b0, 1'b1);
            else
                run_expression($urandom_range(1, 10), 1'b0, 1'b0);
            first_random = 1'b0;
        end
        no_idle = 1'b0;
        start <= 1'b0;

        // Drain: every expected result must come back, then a quiet spell
        // catches any stray extra result.
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d push or operator) in %0d expressions; %0d results back.",
                 words_sent, useful_words, expressions, results_seen);
        $display("Results with empty stack %0d, divide by zero %0d, dropped push %0d.",
                 empty_results, zero_div_results, overflow_results);
        if (fail_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rse_pkg.sv
src/rse_ram.sv
src/rse_front.sv
src/rse_div.sv
src/rse_back.sv
src/rpn_stack_evaluator_top.sv
src/rse_checker.sv
sim/rse_result_checker.sv
sim/rpn_stack_evaluator_top_tb.sv
